FILE: design/hsl2rgb_pkg.sv
`default_nettype none
package hsl2rgb_pkg;

  // default fraction width of hue, saturation and lightness
  localparam int FRAC_BITS_DEF = 12;

  // result formats
  localparam int CH_W   = 8;
  localparam int NIB_W  = 4;
  localparam int PACK_W = 3 * NIB_W;

  // register stages from input transfer to output register
  localparam int PIPE_DEPTH = 5;

endpackage
`default_nettype wire

FILE: design/hsl2rgb_front.sv
`default_nettype none
module hsl2rgb_front #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [FRAC_BITS-1:0]     hue,
  input  wire logic [FRAC_BITS:0]       saturation,
  input  wire logic [FRAC_BITS:0]       lightness,
  // stage A: channel angles in units of 1/(6*ONE) of a turn
  output logic [FRAC_BITS+2:0]          t_red_a_r,
  output logic [FRAC_BITS+2:0]          t_green_a_r,
  output logic [FRAC_BITS+2:0]          t_blue_a_r,
  // stage B: p and q - p, both scaled by ONE^2
  output logic [2*FRAC_BITS:0]          p2_b_r,
  output logic [2*FRAC_BITS:0]          span_b_r
);
  import hsl2rgb_pkg::*;

  localparam int SW = FRAC_BITS + 1;
  localparam int TW = FRAC_BITS + 3;
  localparam int PW = 2 * FRAC_BITS + 1;
  localparam int XW = PW + 2;

  localparam logic [SW-1:0] ONE_S  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SW-1:0] HALF_S = ONE_S >> 1;
  localparam logic [TW-1:0] ONE_T  = TW'(1) << FRAC_BITS;
  localparam logic [TW-1:0] TWO_T  = ONE_T << 1;
  localparam logic [TW-1:0] FOUR_T = ONE_T << 2;
  localparam logic [TW-1:0] SIX_T  = TWO_T + FOUR_T;

  logic [SW-1:0] s_nxt, l_nxt;
  logic [SW-1:0] s_a_r, l_a_r;
  logic [PW-1:0] ls_nxt, ls_a_r;
  logic [TW-1:0] th, tr_sum, tr_nxt, tb_nxt;
  logic [XW-1:0] lo_x, so_x, ls_x, p2_x, span_x;
  logic [PW-1:0] p2_nxt, span_nxt;

  // stage A: clamp, l*s, hue angles
  always_comb begin
    s_nxt  = (saturation > ONE_S) ? ONE_S : saturation;
    l_nxt  = (lightness > ONE_S) ? ONE_S : lightness;
    ls_nxt = PW'(l_nxt) * PW'(s_nxt);
    th     = (TW'(hue) << 2) + (TW'(hue) << 1);
    tr_sum = th + TWO_T;
    tr_nxt = (tr_sum >= SIX_T) ? tr_sum - SIX_T : tr_sum;
    tb_nxt = (th >= TWO_T) ? th - TWO_T : th + FOUR_T;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_a_r       <= s_nxt;
      l_a_r       <= l_nxt;
      ls_a_r      <= ls_nxt;
      t_red_a_r   <= tr_nxt;
      t_green_a_r <= th;
      t_blue_a_r  <= tb_nxt;
    end
  end

  // stage B: p2 and span straight from l, s and l*s; both are known non-negative
  always_comb begin
    lo_x = XW'({l_a_r, {FRAC_BITS{1'b0}}});
    so_x = XW'({s_a_r, {FRAC_BITS{1'b0}}});
    ls_x = XW'(ls_a_r);
    if (l_a_r < HALF_S) begin
      p2_x   = lo_x - ls_x;
      span_x = ls_x << 1;
    end else begin
      p2_x   = lo_x + ls_x - so_x;
      span_x = (so_x << 1) - (ls_x << 1);
    end
    p2_nxt   = p2_x[PW-1:0];
    span_nxt = span_x[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_b_r   <= p2_nxt;
      span_b_r <= span_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/hsl2rgb_chan.sv
`default_nettype none
module hsl2rgb_chan #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [FRAC_BITS+2:0]      t_a,
  input  wire logic [2*FRAC_BITS:0]      p2_b,
  input  wire logic [2*FRAC_BITS:0]      span_b,
  output logic [hsl2rgb_pkg::CH_W-1:0]   byte_e_r
);
  import hsl2rgb_pkg::*;

  localparam int TW  = FRAC_BITS + 3;
  localparam int FW  = FRAC_BITS + 1;
  localparam int PW  = 2 * FRAC_BITS + 1;
  localparam int MW  = PW + FW;
  localparam int CW  = 3 * FRAC_BITS + 1;
  localparam int SCW = CW + CH_W;

  localparam logic [TW-1:0] ONE_T   = TW'(1) << FRAC_BITS;
  localparam logic [TW-1:0] THREE_T = (ONE_T << 1) + ONE_T;
  localparam logic [TW-1:0] FOUR_T  = ONE_T << 2;

  logic [FW-1:0]  f_nxt, f_b_r;
  logic [MW-1:0]  prod_nxt;
  logic [CW-1:0]  prod_c_r;
  logic [PW-1:0]  p2_c_r;
  logic [CW-1:0]  c3_nxt, c3_d_r;
  logic [SCW-1:0] c3_x, scaled;
  logic [CH_W-1:0] byte_nxt;

  // stage B: weight of the span along the piecewise hue rule, 0..ONE
  always_comb begin
    if (t_a < ONE_T) begin
      f_nxt = FW'(t_a);
    end else if (t_a < THREE_T) begin
      f_nxt = FW'(ONE_T);
    end else if (t_a < FOUR_T) begin
      f_nxt = FW'(FOUR_T - t_a);
    end else begin
      f_nxt = '0;
    end
  end

  // stage C: span * weight, never above ONE^3
  assign prod_nxt = span_b * f_b_r;

  // stage D: channel scaled by ONE^3
  assign c3_nxt = CW'({p2_c_r, {FRAC_BITS{1'b0}}}) + prod_c_r;

  // stage E: floor(c * 255)
  always_comb begin
    c3_x     = SCW'(c3_d_r);
    scaled   = (c3_x << CH_W) - c3_x;
    byte_nxt = scaled[3*FRAC_BITS +: CH_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_b_r    <= f_nxt;
      prod_c_r <= prod_nxt[CW-1:0];
      p2_c_r   <= p2_b;
      c3_d_r   <= c3_nxt;
      byte_e_r <= byte_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/hsl_to_rgb_packed12.sv
// HSL to RGB converter. Hue, saturation and lightness arrive as unsigned
// fractions of 2^FRAC_BITS (hue wraps at one turn, saturation and lightness
// above one are taken as one); each transfer returns 8-bit red, green and
// blue, truncated toward zero from channel*255, and a 12-bit word of their
// top nibbles. One colour is accepted per clock while the output is not
// held; each passes through the five-stage pipeline (clamp and l*s, p and
// span, span*weight, sum, *255). When the output is held, the whole
// pipeline holds and the input is not ready.
`default_nettype none
module hsl_to_rgb_packed12 #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [FRAC_BITS-1:0]       in_hue,
  input  wire logic [FRAC_BITS:0]         in_saturation,
  input  wire logic [FRAC_BITS:0]         in_lightness,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [hsl2rgb_pkg::CH_W-1:0]    out_red,
  output logic [hsl2rgb_pkg::CH_W-1:0]    out_green,
  output logic [hsl2rgb_pkg::CH_W-1:0]    out_blue,
  output logic [hsl2rgb_pkg::PACK_W-1:0]  out_packed_color
);
  import hsl2rgb_pkg::*;

  logic                    en;
  logic [PIPE_DEPTH-1:0]   v_r;
  logic [FRAC_BITS+2:0]    t_red_a, t_green_a, t_blue_a;
  logic [2*FRAC_BITS:0]    p2_b, span_b;

  // advance everything unless a result is waiting and not taken
  assign en        = !v_r[PIPE_DEPTH-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = v_r[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  hsl2rgb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk         (clk),
    .en          (en),
    .hue         (in_hue),
    .saturation  (in_saturation),
    .lightness   (in_lightness),
    .t_red_a_r   (t_red_a),
    .t_green_a_r (t_green_a),
    .t_blue_a_r  (t_blue_a),
    .p2_b_r      (p2_b),
    .span_b_r    (span_b)
  );

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
    .clk      (clk),
    .en       (en),
    .t_a      (t_red_a),
    .p2_b     (p2_b),
    .span_b   (span_b),
    .byte_e_r (out_red)
  );

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
    .clk      (clk),
    .en       (en),
    .t_a      (t_green_a),
    .p2_b     (p2_b),
    .span_b   (span_b),
    .byte_e_r (out_green)
  );

  hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
    .clk      (clk),
    .en       (en),
    .t_a      (t_blue_a),
    .p2_b     (p2_b),
    .span_b   (span_b),
    .byte_e_r (out_blue)
  );

  assign out_packed_color = {out_red[CH_W-1 -: NIB_W], out_green[CH_W-1 -: NIB_W],
                             out_blue[CH_W-1 -: NIB_W]};

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipeline valid bits moved during a stall");

  a_valid_shift: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> v_r[PIPE_DEPTH-1:1] == $past(v_r[PIPE_DEPTH-2:0]))
    else $error("valid bit lost or duplicated between stages");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> v_r[0] == $past(in_valid))
    else $error("input transfer did not enter the pipeline");

endmodule
`default_nettype wire
